[rtl/u8v_pkg.sv]
// ----------------------------------------------------------------------------
// u8v_pkg
// shared types, status codes and helpers for the utf-8 stream validator
// ----------------------------------------------------------------------------
`default_nettype none

package u8v_pkg;

   // longest sequence a lead byte may announce, in bytes (2 to 6)
   localparam int MaxSequenceBytes = 6;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FE_FF     = 3'd1,
      ST_STRAY     = 3'd2,
      ST_TOO_LONG  = 3'd3,
      ST_BAD_CONT  = 3'd4,
      ST_TRUNCATED = 3'd5
   } status_type;

   typedef struct packed {
      logic [2:0] due;
      status_type error;
   } state_type;

   function automatic logic [3:0] leading_ones(input logic [7:0] b);
      logic [3:0] n;
      case (b) inside
         8'b0???????: n = 4'd0;
         8'b10??????: n = 4'd1;
         8'b110?????: n = 4'd2;
         8'b1110????: n = 4'd3;
         8'b11110???: n = 4'd4;
         8'b111110??: n = 4'd5;
         8'b1111110?: n = 4'd6;
         8'b11111110: n = 4'd7;
         default:     n = 4'd8;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

[rtl/u8v_step.sv]
// ----------------------------------------------------------------------------
// u8v_step
// next-state and status logic for one byte of the string under test
// ----------------------------------------------------------------------------
`default_nettype none

module u8v_step #(
   parameter int MaxSequenceBytes = u8v_pkg::MaxSequenceBytes
) (
   input  wire logic [7:0]           data_byte,
   input  wire logic                 end_of_string,
   input  wire u8v_pkg::state_type   state_cur,
   output u8v_pkg::state_type        state_nxt,
   output u8v_pkg::status_type       status
);

   always_comb begin
      u8v_pkg::state_type s;
      logic [3:0]         n;

      s = state_cur;
      n = u8v_pkg::leading_ones(data_byte);

      if (state_cur.error != u8v_pkg::ST_OK) begin
         s = state_cur;
      end else if (state_cur.due != 3'd0) begin
         if (data_byte[7:6] != 2'b10) begin
            s.error = u8v_pkg::ST_BAD_CONT;
         end else begin
            s.due = state_cur.due - 3'd1;
         end
      end else if (data_byte == 8'hFF || data_byte == 8'hFE) begin
         s.error = u8v_pkg::ST_FE_FF;
      end else if (n == 4'd1) begin
         s.error = u8v_pkg::ST_STRAY;
      end else if (n > 4'(MaxSequenceBytes)) begin
         s.error = u8v_pkg::ST_TOO_LONG;
      end else if (n != 4'd0) begin
         s.due = 3'(n - 4'd1);
      end

      // status of the string, meaningful on its last byte
      if (s.error != u8v_pkg::ST_OK) begin
         status = s.error;
      end else if (s.due != 3'd0) begin
         status = u8v_pkg::ST_TRUNCATED;
      end else begin
         status = u8v_pkg::ST_OK;
      end

      // end of string returns to the idle state
      if (end_of_string) begin
         state_nxt.due   = 3'd0;
         state_nxt.error = u8v_pkg::ST_OK;
      end else begin
         state_nxt = s;
      end
   end

endmodule

`default_nettype wire

[rtl/utf8_stream_validator.sv]
// ----------------------------------------------------------------------------
// utf8_stream_validator
// checks a byte stream against the up-to-six-byte utf-8 form, one word per
// byte, and gives one status word on the byte that ends each string
// status word: registered from the held last byte once the output is free
// throughput: one byte per cycle; a last byte, and bytes after it, wait only
// while an earlier status word is still not taken by the receiver
// reset: synchronous, clears the sequence state and all valid flags
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_validator #(
   parameter int MaxSequenceBytes = u8v_pkg::MaxSequenceBytes
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // end_of_string
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [2:0] status, [7:3] zero
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff, in_byte_in;
   logic                 in_last_ff, in_last_in;
   u8v_pkg::state_type   state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   u8v_pkg::status_type  rsp_status_ff, rsp_status_in;

   u8v_pkg::state_type   step_state;
   u8v_pkg::status_type  step_status;
   logic                 advance;

   u8v_step #(
      .MaxSequenceBytes (MaxSequenceBytes)
   ) u_step (
      .data_byte     (in_byte_ff),
      .end_of_string (in_last_ff),
      .state_cur     (state_ff),
      .state_nxt     (step_state),
      .status        (step_status)
   );

   // a held word moves on unless its status word has nowhere to go
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      in_last_in    = in_last_ff;
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         in_valid_in = 1'b0;
         state_in    = step_state;
         if (in_last_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = step_status;
         end
      end

      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff.due   <= 3'd0;
         state_ff.error <= u8v_pkg::ST_OK;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
      in_byte_ff    <= in_byte_in;
      in_last_ff    <= in_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_status_ff};

endmodule

`default_nettype wire
